[hw/rtl/adl32_pkg.sv]
// Shared types, constants and helpers for the Adler-32 checksum block.
package adl32_pkg;

   localparam int SUM_W   = 16;
   localparam int COUNT_W = 5;
   localparam int WORD_W  = 64;
   localparam int CHECK_W = 2 * SUM_W;

   typedef logic [SUM_W-1:0]   sum_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [CHECK_W-1:0] check_type;

   // Adler modulus and 2^16 mod 65521, used to fold the high bits back in
   localparam sum_type ADLER_MOD = 16'd65521;
   localparam int      FOLD_K    = 15;

   // Input must be below 2 * ADLER_MOD.
   function automatic sum_type reduce_once(input logic [SUM_W:0] value);
      logic [SUM_W:0] diff;
      begin
         diff = value - {1'b0, ADLER_MOD};
         reduce_once = (value >= {1'b0, ADLER_MOD}) ? diff[SUM_W-1:0] : value[SUM_W-1:0];
      end
   endfunction

endpackage

[hw/rtl/adl32_if.sv]
// Channel interfaces: data beats in, checksum out, start value writes.
interface adl32_req_if;
   import adl32_pkg::*;
   logic      valid;
   logic      ready;
   word_type  data_low;
   word_type  data_high;
   count_type byte_count;
   logic      first;
   logic      last;

   modport source (output valid, data_low, data_high, byte_count, first, last, input ready);
   modport sink   (input valid, data_low, data_high, byte_count, first, last, output ready);
endinterface

interface adl32_rsp_if;
   import adl32_pkg::*;
   logic      valid;
   logic      ready;
   check_type checksum;

   modport source (output valid, checksum, input ready);
   modport sink   (input valid, checksum, output ready);
endinterface

interface adl32_csr_if;
   import adl32_pkg::*;
   logic      valid;
   logic      ready;
   check_type start_value;

   modport source (output valid, start_value, input ready);
   modport sink   (input valid, start_value, output ready);
endinterface

[hw/rtl/adler32_checksum_16byte.sv]
// Path: input register, byte-sum register, then the loop stage loads the result register.
// Throughput: one beat per cycle while the pipe is not stalled; the update of the two running
//   sums (multiply by count, add, fold, one conditional subtract) sets that rate.
// A waiting checksum stalls the pipe only when the next beat to retire is also last.
// Reset (synchronous, active high): pipe empty, low sum 1, high sum 0,
//   start value 1.
module adler32_checksum_16byte #(
   parameter int BYTES_PER_ITEM = 16
) (
   input logic        clock,
   input logic        reset,
   adl32_csr_if.sink  csr_chan,
   adl32_req_if.sink  req_chan,
   adl32_rsp_if.source rsp_chan
);
   import adl32_pkg::*;

   // Stage widths follow from the lane count.
   localparam int WEIGHT_W = $clog2(BYTES_PER_ITEM + 1);
   localparam int PROD_W   = WEIGHT_W + 8;
   localparam int BSUM_MAX = 255 * BYTES_PER_ITEM;
   localparam int BSUM_W   = $clog2(BSUM_MAX + 1);
   localparam int WSUM_MAX = 255 * BYTES_PER_ITEM * (BYTES_PER_ITEM + 1) / 2;
   localparam int WSUM_W   = $clog2(WSUM_MAX + 1);
   localparam int T2_MAX   = 65535 + BYTES_PER_ITEM * 65535 + WSUM_MAX;
   localparam int T2_W     = $clog2(T2_MAX + 1);
   localparam int MUL_W    = SUM_W + COUNT_W;

   // ---------------- control ----------------
   logic      stall;
   logic      advance;
   logic      loop_fire;

   // input register: raw beat
   logic      in_valid_ff, in_valid_in;
   word_type  in_low_ff, in_low_in;
   word_type  in_high_ff, in_high_in;
   count_type in_count_ff, in_count_in;
   logic      in_first_ff, in_first_in;
   logic      in_last_ff, in_last_in;

   // byte-sum stage: plain and weighted byte sums, saturated count
   logic              p2_valid_ff, p2_valid_in;
   logic [BSUM_W-1:0] p2_bsum_ff, p2_bsum_in;
   logic [WSUM_W-1:0] p2_wsum_ff, p2_wsum_in;
   count_type         p2_count_ff, p2_count_in;
   logic              p2_first_ff, p2_first_in;
   logic              p2_last_ff, p2_last_in;
   count_type         n_sat;

   // running sums and configuration
   sum_type   low_sum_ff, low_sum_in;
   sum_type   high_sum_ff, high_sum_in;
   check_type start_value_ff, start_value_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   check_type rsp_checksum_ff, rsp_checksum_in;

   // loop-stage datapath
   sum_type          s1_sel, s2_sel;
   logic [SUM_W:0]   t1;
   logic [MUL_W-1:0] mul;
   logic [T2_W-1:0]  t2;
   logic [SUM_W:0]   fold;
   sum_type          low_next, high_next;

   // The pipe only holds when a last beat must retire into a full result register.
   assign stall     = p2_valid_ff && p2_last_ff && rsp_valid_ff && !rsp_chan.ready;
   assign advance   = !stall;
   assign loop_fire = advance && p2_valid_ff;

   assign req_chan.ready    = advance;
   assign csr_chan.ready    = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.checksum = rsp_checksum_ff;

   // ---------------- input register ----------------
   always_comb begin
      in_valid_in = advance ? req_chan.valid      : in_valid_ff;
      in_low_in   = advance ? req_chan.data_low   : in_low_ff;
      in_high_in  = advance ? req_chan.data_high  : in_high_ff;
      in_count_in = advance ? req_chan.byte_count : in_count_ff;
      in_first_in = advance ? req_chan.first      : in_first_ff;
      in_last_in  = advance ? req_chan.last       : in_last_ff;
   end

   // ---------------- byte sums ----------------
   // Weighted sum uses weight n - i for lane i, zero past the count.
   assign n_sat = (in_count_ff > COUNT_W'(BYTES_PER_ITEM)) ? COUNT_W'(BYTES_PER_ITEM)
                                                           : in_count_ff;

   always_comb begin
      logic [2*WORD_W-1:0] data_all;
      logic [7:0]          bval;
      logic [WEIGHT_W-1:0] weight;
      logic [PROD_W-1:0]   prod;
      data_all   = {in_high_ff, in_low_ff};
      p2_bsum_in = '0;
      p2_wsum_in = '0;
      for (int i = 0; i < BYTES_PER_ITEM; i++) begin
         bval   = data_all[8*i +: 8];
         weight = (COUNT_W'(i) < n_sat) ? WEIGHT_W'(n_sat - COUNT_W'(i)) : '0;
         prod   = PROD_W'(weight) * PROD_W'(bval);
         if (weight != '0) begin
            p2_bsum_in = p2_bsum_in + BSUM_W'(bval);
         end
         p2_wsum_in = p2_wsum_in + WSUM_W'(prod);
      end
      if (!advance) begin
         p2_bsum_in = p2_bsum_ff;
         p2_wsum_in = p2_wsum_ff;
      end
   end

   always_comb begin
      p2_valid_in = advance ? in_valid_ff : p2_valid_ff;
      p2_count_in = advance ? n_sat       : p2_count_ff;
      p2_first_in = advance ? in_first_ff : p2_first_ff;
      p2_last_in  = advance ? in_last_ff  : p2_last_ff;
   end

   // ---------------- sum update loop ----------------
   // low  = (s1 + B) mod M
   // high = (s2 + n*s1 + sum (n-i)*b_i) mod M, folded with 2^16 = 15 (mod M)
   always_comb begin
      s1_sel    = p2_first_ff ? start_value_ff[SUM_W-1:0]       : low_sum_ff;
      s2_sel    = p2_first_ff ? start_value_ff[CHECK_W-1:SUM_W] : high_sum_ff;
      t1        = {1'b0, s1_sel} + (SUM_W + 1)'(p2_bsum_ff);
      low_next  = reduce_once(t1);
      mul       = {COUNT_W'(0), s1_sel} * {SUM_W'(0), p2_count_ff};
      t2        = T2_W'(s2_sel) + T2_W'(mul) + T2_W'(p2_wsum_ff);
      fold      = (SUM_W + 1)'(t2[SUM_W-1:0])
                + (SUM_W + 1)'(t2[T2_W-1:SUM_W]) * (SUM_W + 1)'(FOLD_K);
      high_next = reduce_once(fold);
   end

   always_comb begin
      low_sum_in      = loop_fire ? low_next  : low_sum_ff;
      high_sum_in     = loop_fire ? high_next : high_sum_ff;
      start_value_in  = csr_chan.valid ? csr_chan.start_value : start_value_ff;
      rsp_checksum_in = rsp_checksum_ff;
      if (loop_fire && p2_last_ff) begin
         rsp_valid_in    = 1'b1;
         rsp_checksum_in = {high_next, low_next};
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         p2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         low_sum_ff     <= sum_type'(1);
         high_sum_ff    <= '0;
         start_value_ff <= check_type'(1);
      end else begin
         in_valid_ff    <= in_valid_in;
         p2_valid_ff    <= p2_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         low_sum_ff     <= low_sum_in;
         high_sum_ff    <= high_sum_in;
         start_value_ff <= start_value_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_low_ff       <= in_low_in;
      in_high_ff      <= in_high_in;
      in_count_ff     <= in_count_in;
      in_first_ff     <= in_first_in;
      in_last_ff      <= in_last_in;
      p2_bsum_ff      <= p2_bsum_in;
      p2_wsum_ff      <= p2_wsum_in;
      p2_count_ff     <= p2_count_in;
      p2_first_ff     <= p2_first_in;
      p2_last_ff      <= p2_last_in;
      rsp_checksum_ff <= rsp_checksum_in;
   end

   // ---------------- assertions ----------------
   sums_in_range: assert property (@(posedge clock) disable iff (reset)
      (low_sum_ff < ADLER_MOD) && (high_sum_ff < ADLER_MOD))
      else $error("running sum not reduced");

   last_emits: assert property (@(posedge clock) disable iff (reset)
      (loop_fire && p2_last_ff) |=>
         (rsp_valid_ff && (rsp_checksum_ff == {high_sum_ff, low_sum_ff})))
      else $error("last beat did not load the checksum");

   sums_hold: assert property (@(posedge clock) disable iff (reset)
      !loop_fire |=> ($stable(low_sum_ff) && $stable(high_sum_ff)))
      else $error("sums changed without a retiring beat");

endmodule
